FILE: hdl/sgdm_pkg.sv
// Shared types, constants and saturation helpers for the SGD momentum update block.
package sgdm_pkg;

  // Field widths and fixed-point format
  localparam int VAL_W  = 32;    // Q16.16 signed values
  localparam int COEF_W = 16;    // Q0.16 unsigned coefficients
  localparam int FRAC_W = 16;
  localparam int IDX_W  = 10;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_PARAMS_DEF = 1024;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [COEF_W-1:0]       coef_t;
  typedef logic [MODE_W-1:0]       mode_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

  // Request modes; the unused code behaves as a read
  localparam mode_t MODE_LOAD   = 2'd0;
  localparam mode_t MODE_UPDATE = 2'd1;
  localparam mode_t MODE_READ   = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t REG_LEARNING_RATE = 2'd0;
  localparam cfg_idx_t REG_MOMENTUM      = 2'd1;
  localparam cfg_idx_t REG_WEIGHT_DECAY  = 2'd2;

  localparam coef_t LR_RESET  = 16'd655;
  localparam coef_t MOM_RESET = 16'd58982;
  localparam coef_t WD_RESET  = 16'd0;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // One stored entry
  typedef struct packed {
    logic flag;
    val_t vel;
    val_t par;
  } entry_t;

  // Item handed from the control stage to the datapath
  typedef struct packed {
    mode_t  mode;
    val_t   value;
    logic   regularize;
    entry_t ent;
  } dp_in_t;

  // Saturate a value one bit wider than VAL_W
  function automatic val_t sat_w1(input logic signed [VAL_W:0] x);
    val_t r;
    if (x[VAL_W] == x[VAL_W-1]) begin
      r = x[VAL_W-1:0];
    end else if (x[VAL_W]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

  // Saturate a value two bits wider than VAL_W
  function automatic val_t sat_w2(input logic signed [VAL_W+1:0] x);
    val_t r;
    if (x[VAL_W+1:VAL_W-1] == 3'b000 || x[VAL_W+1:VAL_W-1] == 3'b111) begin
      r = x[VAL_W-1:0];
    end else if (x[VAL_W+1]) begin
      r = VAL_MIN;
    end else begin
      r = VAL_MAX;
    end
    return r;
  endfunction

endpackage

FILE: hdl/sgdm_dp.sv
// Three-stage arithmetic datapath: products, velocity sum, parameter step.
module sgdm_dp import sgdm_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  dp_in_t d_in,
  input  coef_t  lr,
  input  coef_t  mom,
  input  coef_t  wd,
  output entry_t res
);

  localparam int PROD_W = COEF_W + 1 + VAL_W;

  logic signed [COEF_W:0]   lr_s, mom_s, wd_s;
  logic signed [PROD_W-1:0] prod_g, prod_v, prod_d;
  entry_t                   base1;

  logic   s2_upd_r;
  entry_t s2_base_r;
  val_t   s2_pg_r, s2_pv_r, s2_pd_r;

  logic signed [VAL_W:0] vsum, pdec, ppart;
  val_t                  vnew;

  logic                  s3_upd_r;
  entry_t                s3_base_r;
  val_t                  s3_vnew_r;
  logic signed [VAL_W:0] s3_ppart_r;

  logic signed [VAL_W+1:0] pdiff;
  val_t                    pnew;

  // Stage 1: coefficient products, floor-shifted by the fraction width
  assign lr_s  = $signed({1'b0, lr});
  assign mom_s = $signed({1'b0, mom});
  assign wd_s  = $signed({1'b0, wd});
  assign prod_g = lr_s  * d_in.value;
  assign prod_v = mom_s * d_in.ent.vel;
  assign prod_d = wd_s  * d_in.ent.par;

  // load builds the entry outright; read and update start from the stored one
  always_comb begin
    base1 = d_in.ent;
    if (d_in.mode == MODE_LOAD) begin
      base1.flag = d_in.regularize;
      base1.vel  = '0;
      base1.par  = d_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_upd_r  <= (d_in.mode == MODE_UPDATE);
      s2_base_r <= base1;
      s2_pg_r   <= prod_g[FRAC_W+VAL_W-1:FRAC_W];
      s2_pv_r   <= prod_v[FRAC_W+VAL_W-1:FRAC_W];
      s2_pd_r   <= prod_d[FRAC_W+VAL_W-1:FRAC_W];
    end
  end

  // Stage 2: new velocity, and parameter less decay term
  assign vsum  = {s2_pg_r[VAL_W-1], s2_pg_r} + {s2_pv_r[VAL_W-1], s2_pv_r};
  assign vnew  = sat_w1(vsum);
  assign pdec  = s2_base_r.flag ? {s2_pd_r[VAL_W-1], s2_pd_r} : '0;
  assign ppart = {s2_base_r.par[VAL_W-1], s2_base_r.par} - pdec;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_upd_r   <= s2_upd_r;
      s3_base_r  <= s2_base_r;
      s3_vnew_r  <= vnew;
      s3_ppart_r <= ppart;
    end
  end

  // Stage 3: subtract velocity and saturate
  assign pdiff = {s3_ppart_r[VAL_W], s3_ppart_r}
               - {{2{s3_vnew_r[VAL_W-1]}}, s3_vnew_r};
  assign pnew  = sat_w2(pdiff);

  always_comb begin
    res = s3_base_r;
    if (s3_upd_r) begin
      res.vel = s3_vnew_r;
      res.par = pnew;
    end
  end

endmodule

FILE: hdl/sgd_momentum_update.sv
// Top level: entry memory, request pipeline control, hazard interlock and result register.
// Throughput: one request per cycle while results are not stalled; a request to an entry
// that a load or update still holds in the first or second pipeline stage waits until it
// has moved on, longer while results are stalled (the write-back is forwarded from the
// third stage; earlier stages are interlocked at the memory read port). Reset:
// configuration returns to its defaults and the pipeline empties; the entry memory is not
// cleared, entries must be loaded before use.
module sgd_momentum_update import sgdm_pkg::*; #(
  parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  mode_t              in_mode,
  input  logic [IDX_W-1:0]   in_index,
  input  val_t               in_value,
  input  logic               in_regularize,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   out_index,
  output val_t               out_parameter_res,
  output val_t               out_velocity,
  // configuration
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  coef_t              cfg_wdata
);

  localparam int AW = $clog2(NUM_PARAMS);
  localparam logic [63:0] NP64 = 64'(NUM_PARAMS);

  // Wrap the request index into the store by constant shifted subtraction
  function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] r;
    r = x;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (64'(r) >= (NP64 << k)) begin
        r = IDX_W'(64'(r) - (NP64 << k));
      end
    end
    return AW'(r);
  endfunction

  coef_t lr_r, mom_r, wd_r;

  logic [AW-1:0] in_idx_w;
  logic          in_mod, accept, hazard, pipe_en, wb_en;

  entry_t        ent_mem [NUM_PARAMS];
  entry_t        rd_r, fwd_ent_r, s1_ent, wb_ent;

  logic          s1_v_r, s2_v_r, s3_v_r;
  logic          s1_mod_r, s2_mod_r, s3_mod_r;
  logic [AW-1:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic          s1_fwd_r;
  mode_t         s1_mode_r;
  val_t          s1_val_r;
  logic          s1_reg_r;
  dp_in_t        dp_in;

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_index_r;
  val_t             out_par_r, out_vel_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= LR_RESET;
      mom_r <= MOM_RESET;
      wd_r  <= WD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARNING_RATE: lr_r  <= cfg_wdata;
        REG_MOMENTUM:      mom_r <= cfg_wdata;
        REG_WEIGHT_DECAY:  wd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request side: pipeline advances unless a finished result is blocked
  assign in_idx_w = wrap_idx(in_index);
  assign in_mod   = (in_mode == MODE_LOAD) || (in_mode == MODE_UPDATE);
  assign pipe_en  = !s3_v_r || !out_valid_r || !out_stall;
  assign hazard   = (s1_v_r && s1_mod_r && (s1_idx_r == in_idx_w))
                 || (s2_v_r && s2_mod_r && (s2_idx_r == in_idx_w));
  assign in_stall = !rst_n || !pipe_en || hazard;
  assign accept   = in_valid && !in_stall;

  // Write-back from the last stage as it hands over to the result register
  assign wb_en = s3_v_r && s3_mod_r && pipe_en;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wb_en) begin
      ent_mem[s3_idx_r] <= wb_ent;
    end
    if (pipe_en) begin
      rd_r <= ent_mem[in_idx_w];
    end
  end

  // Bypass for a write-back landing at the same edge as the read
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      fwd_ent_r <= wb_ent;
      s1_mode_r <= in_mode;
      s1_val_r  <= in_value;
      s1_reg_r  <= in_regularize;
      s1_idx_r  <= in_idx_w;
      s1_mod_r  <= in_mod;
      s2_idx_r  <= s1_idx_r;
      s2_mod_r  <= s1_mod_r;
      s3_idx_r  <= s2_idx_r;
      s3_mod_r  <= s2_mod_r;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      s1_fwd_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r   <= accept;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
      s1_fwd_r <= wb_en && (s3_idx_r == in_idx_w);
    end
  end

  assign s1_ent = s1_fwd_r ? fwd_ent_r : rd_r;

  always_comb begin
    dp_in.mode       = s1_mode_r;
    dp_in.value      = s1_val_r;
    dp_in.regularize = s1_reg_r;
    dp_in.ent        = s1_ent;
  end

  sgdm_dp u_dp (
    .clk  (clk),
    .en   (pipe_en),
    .d_in (dp_in),
    .lr   (lr_r),
    .mom  (mom_r),
    .wd   (wd_r),
    .res  (wb_ent)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s3_v_r && pipe_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && pipe_en) begin
      out_index_r <= IDX_W'(s3_idx_r);
      out_par_r   <= wb_ent.par;
      out_vel_r   <= wb_ent.vel;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_index         = out_index_r;
  assign out_parameter_res = out_par_r;
  assign out_velocity      = out_vel_r;

  // A blocked last stage keeps its request
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !pipe_en |=> s3_v_r && $stable(s3_idx_r))
    else $error("last stage lost a request while blocked");

  // The last stage lands in the result register with its index
  a_s3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && pipe_en |=> out_valid_r && (out_index_r == IDX_W'($past(s3_idx_r))))
    else $error("result register missed the last stage");

  // No request to an entry accepted while its load or update sits in the first stage
  a_interlock_1: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mod |=> !(accept && (in_idx_w == $past(in_idx_w))))
    else $error("same-entry request accepted one cycle after a write");

  // Nor while that load or update sits in the second stage
  a_interlock_2: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mod |-> ##2 !(accept && (in_idx_w == $past(in_idx_w, 2))))
    else $error("same-entry request accepted two cycles after a write");

endmodule

FILE: test/sgd_momentum_update_tb.sv
// Self-checking testbench for sgd_momentum_update: directed and random requests, Q16.16 predictor.
`timescale 1ns / 100ps

module sgd_momentum_update_tb import sgdm_pkg::*; ();

  // Spare mode code, treated by the block as a read
  localparam mode_t MODE_SPARE = 2'd3;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int DRAIN_GUARD = 50000;

  typedef struct {
    mode_t            mode;
    logic [IDX_W-1:0] index;
    val_t             value;
    logic             regularize;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    val_t             par;
    val_t             vel;
  } entry_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  mode_t            in_mode = MODE_LOAD;
  logic [IDX_W-1:0] in_index = '0;
  val_t             in_value = '0;
  logic             in_regularize = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_index;
  val_t             out_parameter_res;
  val_t             out_velocity;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = REG_LEARNING_RATE;
  coef_t            cfg_wdata = '0;

  // Predictor state: entry memory and coefficient copies
  val_t  par_mem [NUM_PARAMS_DEF];
  val_t  vel_mem [NUM_PARAMS_DEF];
  logic  flag_mem [NUM_PARAMS_DEF];
  logic  loaded [NUM_PARAMS_DEF];
  coef_t lr_coef = LR_RESET;
  coef_t mom_coef = MOM_RESET;
  coef_t wd_coef = WD_RESET;

  request_t      req_queue [$];
  entry_result_t expected_entries [$];
  request_t      driven_req;
  int            send_idle_pct = 9;
  int            recv_stall_pct = 86;
  int            fail_count = 0;

  sgd_momentum_update dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_index          (in_index),
    .in_value          (in_value),
    .in_regularize     (in_regularize),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_index         (out_index),
    .out_parameter_res (out_parameter_res),
    .out_velocity      (out_velocity),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // coef * value in Q0.16, floor rounding via arithmetic shift
  function automatic longint coef_scale(input coef_t c, input longint v);
    longint prod;
    prod = longint'(c) * v;
    return prod >>> FRAC_W;
  endfunction

  function automatic longint saturate_q16(input longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  // Apply one request to the predictor state and return the entry it reports
  function automatic entry_result_t apply_request(input request_t r);
    entry_result_t res;
    longint p;
    longint v;
    longint step;
    case (r.mode)
      MODE_LOAD: begin
        par_mem[r.index]  = r.value;
        vel_mem[r.index]  = '0;
        flag_mem[r.index] = r.regularize;
      end
      MODE_UPDATE: begin
        p = par_mem[r.index];
        v = saturate_q16(coef_scale(lr_coef, r.value) + coef_scale(mom_coef, vel_mem[r.index]));
        step = v;
        if (flag_mem[r.index]) step += coef_scale(wd_coef, p);
        vel_mem[r.index] = val_t'(v);
        par_mem[r.index] = val_t'(saturate_q16(p - step));
      end
      default: ;
    endcase
    res.index = r.index;
    res.par   = par_mem[r.index];
    res.vel   = vel_mem[r.index];
    return res;
  endfunction

  // Queue a request; updates and reads only ever target loaded entries
  task automatic push_req(input mode_t m, input int idx, input val_t v, input logic rg);
    request_t r;
    r.mode = m;
    r.index = idx[IDX_W-1:0];
    r.value = v;
    r.regularize = rg;
    if (m == MODE_LOAD) loaded[idx] = 1'b1;
    req_queue.push_back(r);
  endtask

  function automatic val_t pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      case ($urandom_range(4))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return '0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (sel < 50) return val_t'($signed($urandom_range(2097151)) - 1048576);
    return val_t'($urandom);
  endfunction

  // Random requests, mostly hitting a few hot entries to stress the interlock
  task automatic gen_random(input int n);
    int hot [8];
    int idx;
    int unsigned sel;
    mode_t m;
    foreach (hot[k]) hot[k] = $urandom_range(NUM_PARAMS_DEF - 1);
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(99) < 60) ? hot[$urandom_range(7)] : $urandom_range(NUM_PARAMS_DEF - 1);
      sel = $urandom_range(99);
      if (!loaded[idx] || sel < 20) m = MODE_LOAD;
      else if (sel < 75) m = MODE_UPDATE;
      else if (sel < 90) m = MODE_READ;
      else m = MODE_SPARE;
      push_req(m, idx, pick_value(), 1'($urandom_range(1)));
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input coef_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEARNING_RATE: lr_coef = data;
      REG_MOMENTUM:      mom_coef = data;
      REG_WEIGHT_DECAY:  wd_coef = data;
      default: ;
    endcase
  endtask

  // Wait until every queued request has been answered, then let the pipe settle;
  // sampled on the falling edge so the driver's updates have all landed
  task automatic drain();
    int guard;
    guard = 0;
    while ((req_queue.size() != 0 || in_valid || expected_entries.size() != 0) &&
           guard < DRAIN_GUARD) begin
      @(negedge clk);
      guard++;
    end
    if (guard >= DRAIN_GUARD) begin
      $error("pipeline did not drain, %0d results outstanding", expected_entries.size());
      fail_count++;
    end
    repeat (6) @(posedge clk);
  endtask

  // Request driver: predicts each request as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_entries.push_back(apply_request(driven_req));
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        driven_req     = req_queue.pop_front();
        in_valid      <= 1'b1;
        in_mode       <= driven_req.mode;
        in_index      <= driven_req.index;
        in_value      <= driven_req.value;
        in_regularize <= driven_req.regularize;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: random back-pressure and field-by-field compare
  always @(posedge clk) begin : result_monitor
    entry_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_entries.size() == 0) begin
          $error("unexpected result for entry %0d", out_index);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          if (out_index !== want.index) begin
            $error("out_index: expected %0d, got %0d", want.index, out_index);
            fail_count++;
          end
          if (out_parameter_res !== want.par) begin
            $error("parameter_res: expected %0d, got %0d", want.par, out_parameter_res);
            fail_count++;
          end
          if (out_velocity !== want.vel) begin
            $error("velocity: expected %0d, got %0d", want.vel, out_velocity);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    coef_t lr;
    coef_t mom;
    coef_t wd;
    foreach (loaded[k]) loaded[k] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at reset coefficients: extremes, saturation, spare mode, hazards
    push_req(MODE_LOAD,   0,    VAL_MAX, 1'b1);
    push_req(MODE_LOAD,   1023, VAL_MIN, 1'b0);
    push_req(MODE_UPDATE, 1023, VAL_MAX, 1'b1);
    push_req(MODE_UPDATE, 0,    VAL_MIN, 1'b0);
    push_req(MODE_READ,   0,    VAL_MAX, 1'b1);
    push_req(MODE_SPARE,  1023, '0,      1'b0);
    push_req(MODE_LOAD,   512,  '0,      1'b0);
    push_req(MODE_UPDATE, 512,  1,       1'b0);
    push_req(MODE_UPDATE, 512,  -1,      1'b0);
    push_req(MODE_UPDATE, 512,  '0,      1'b1);
    push_req(MODE_LOAD,   341,  32'sh5555_5555, 1'b1);
    push_req(MODE_LOAD,   682,  32'shAAAA_AAAA, 1'b0);
    push_req(MODE_UPDATE, 341,  32'sh7FFF_0000, 1'b0);
    push_req(MODE_UPDATE, 682,  -65536,  1'b1);
    push_req(MODE_READ,   341,  -1,      1'b1);
    push_req(MODE_LOAD,   0,    -1,      1'b0);
    push_req(MODE_UPDATE, 0,    VAL_MAX, 1'b0);
    push_req(MODE_UPDATE, 0,    VAL_MAX, 1'b0);
    push_req(MODE_READ,   682,  '0,      1'b0);
    push_req(MODE_SPARE,  0,    VAL_MIN, 1'b1);
    drain();

    // Random phases over a range of coefficient settings and idle patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin lr = 16'hFFFF; mom = 16'hFFFF; wd = 16'hFFFF; end
        1: begin lr = 16'h0000; mom = 16'h0000; wd = 16'h0000; end
        2: begin lr = LR_RESET; mom = MOM_RESET; wd = 16'd3277; end
        4: begin lr = 16'hFFFF; mom = 16'h0000; wd = 16'h8000; end
        default: begin
          lr  = coef_t'($urandom_range(65535));
          mom = coef_t'($urandom_range(65535));
          wd  = coef_t'($urandom_range(65535));
        end
      endcase
      write_reg(REG_LEARNING_RATE, lr);
      write_reg(REG_MOMENTUM, mom);
      write_reg(REG_WEIGHT_DECAY, wd);
      send_idle_pct  = (ph < 2) ? 9 : (ph < 4) ? 86 : 0;
      recv_stall_pct = (ph < 2) ? 86 : (ph < 4) ? 9 : 0;
      gen_random(225);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_800_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sgd_momentum_update.f
hdl/sgdm_pkg.sv
hdl/sgdm_dp.sv
hdl/sgd_momentum_update.sv
test/sgd_momentum_update_tb.sv
